[src/cassette_block_framer_assert.svh]
// Assertion macros for the framer module.
`ifndef CASSETTE_BLOCK_FRAMER_ASSERT_SVH
`define CASSETTE_BLOCK_FRAMER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check a property on every clock edge outside reset.
`define CBF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define CBF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CBF_ASSERT(lbl, prop, msg)
`define CBF_ASSERT_RST(lbl, prop, msg)

`endif

`endif

[src/cbf_pkg.sv]
package cbf_pkg;

  // Default sizes
  localparam int BLOCK_MAX_DEF  = 255;
  localparam int LEADER_LEN_DEF = 128;

  // Field widths
  localparam int BYTE_W = 8;
  localparam int CMD_W  = 2;
  localparam int NAME_W = 64;
  localparam int ADDR_W = 16;
  localparam int CFG_W  = 64;
  localparam int IDX_W  = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLOSE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_NAME = 2'd0;
  localparam logic [IDX_W-1:0] REG_EXEC = 2'd1;
  localparam logic [IDX_W-1:0] REG_LOAD = 2'd2;

  // Frame bytes
  localparam logic [BYTE_W-1:0] SYNC_BYTE  = 8'h55;
  localparam logic [BYTE_W-1:0] START_BYTE = 8'h3c;
  localparam logic [BYTE_W-1:0] TYPE_NAME  = 8'h00;
  localparam logic [BYTE_W-1:0] TYPE_DATA  = 8'h01;
  localparam logic [BYTE_W-1:0] TYPE_END   = 8'hff;
  localparam logic [BYTE_W-1:0] FILE_TYPE  = 8'h02;
  localparam logic [BYTE_W-1:0] HEAD_LEN   = 8'd15;

  localparam logic [NAME_W-1:0] NAME_RESET = 64'h2020_2020_2020_2020;

  // Name block payload byte at position idx
  function automatic logic [BYTE_W-1:0] header_byte(
    input logic [BYTE_W-1:0] idx,
    input logic [NAME_W-1:0] name,
    input logic [ADDR_W-1:0] exec_a,
    input logic [ADDR_W-1:0] load_a
  );
    logic [ADDR_W-1:0] ex;
    logic [BYTE_W-1:0] b;
    ex = (exec_a != '0) ? exec_a : load_a;
    b  = '0;
    if (idx < 8'd8) begin
      b = name[(7 - idx[2:0]) * BYTE_W +: BYTE_W];
    end else begin
      unique case (idx)
        8'd8:    b = FILE_TYPE;
        8'd11:   b = ex[15:8];
        8'd12:   b = ex[7:0];
        8'd13:   b = load_a[15:8];
        8'd14:   b = load_a[7:0];
        default: b = '0;
      endcase
    end
    return b;
  endfunction

endpackage

[src/cbf_ram.sv]
module cbf_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 255,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/cassette_block_framer.sv]
// Cassette image framer.
// Input channel (in_valid/in_ready) takes one command per transaction: push a
// program byte, close the data stream, or tick to pull up to one image byte.
// Result channel (res_valid/res_ready) returns exactly one result per input
// transaction: out_valid/out_byte for the image byte, image_end on the last
// byte of the end block, push_accepted for a push or close that was taken.
// The image is a 0x55 leader, the name block, a second leader, data blocks
// of up to BLOCK_MAX bytes and an end block.
// A result is valid the cycle after its input is accepted. Throughput is
// one transaction per cycle while results are taken; the block buffer is
// read one index ahead through its registered port, so data bytes stream.
// The result register frees in_ready whenever it is empty or taken in the
// same cycle; while the receiver stalls, in_ready stays low and the result
// holds. Reset (rst, synchronous) clears phase, counters, sums and flags,
// sets the name register to eight spaces and both addresses to zero.
// Configuration writes (cfg_we, cfg_index, cfg_data) apply at once.
module cassette_block_framer
  import cbf_pkg::*;
#(
  parameter int BLOCK_MAX  = cbf_pkg::BLOCK_MAX_DEF,
  parameter int LEADER_LEN = cbf_pkg::LEADER_LEN_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cbf_pkg::CMD_W-1:0]   cmd,
  input  logic [cbf_pkg::BYTE_W-1:0]  data_byte,
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic                        out_valid,
  output logic [cbf_pkg::BYTE_W-1:0]  out_byte,
  output logic                        image_end,
  output logic                        push_accepted,
  input  logic                        cfg_we,
  input  logic [cbf_pkg::IDX_W-1:0]   cfg_index,
  input  logic [cbf_pkg::CFG_W-1:0]   cfg_data
);

  `include "cassette_block_framer_assert.svh"

  localparam int AW = $clog2(BLOCK_MAX + 1);

  typedef enum logic [2:0] {
    PH_LEAD1, PH_HEAD, PH_LEAD2, PH_DATA, PH_END, PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    FS_IDLE, FS_SYNC, FS_TYPE, FS_LEN, FS_DATA, FS_SUM, FS_TAIL
  } step_t;

  // Configuration registers
  logic [NAME_W-1:0] name_chars;
  logic [ADDR_W-1:0] exec_address;
  logic [ADDR_W-1:0] load_address;

  // Framing state
  phase_t            phase, phase_next;
  step_t             frame_step, frame_step_next;
  logic [BYTE_W-1:0] leader_count, leader_count_next;
  logic [BYTE_W-1:0] byte_index, byte_index_next;
  logic [AW-1:0]     fill_count, fill_count_next;
  logic              closed_flag, closed_flag_next;
  logic [BYTE_W-1:0] running_sum, running_sum_next;

  // Result register inputs
  logic              valid_next, iend_next, acc_next;
  logic [BYTE_W-1:0] byte_next;

  logic              accept;
  logic              ram_we;
  logic [BYTE_W-1:0] rd_data;

  // Frame engine signals
  logic [BYTE_W-1:0] f_type, f_len, f_payload, f_byte, f_sum, f_idx, idx_inc;
  step_t             f_step;
  logic              f_last;
  logic [BYTE_W-1:0] lc_inc;
  logic              emitting;

  assign in_ready = !res_valid || res_ready;
  assign accept   = in_valid && in_ready;
  assign emitting = (phase == PH_DATA) && (frame_step != FS_IDLE);
  assign lc_inc   = leader_count + 8'd1;
  assign idx_inc  = byte_index + 8'd1;

  // Select block type, length and payload source for the current phase
  always_comb begin
    f_type = TYPE_END;
    f_len  = '0;
    unique case (phase)
      PH_HEAD: begin
        f_type = TYPE_NAME;
        f_len  = HEAD_LEN;
      end
      PH_DATA: begin
        f_type = TYPE_DATA;
        f_len  = BYTE_W'(fill_count);
      end
      default: begin
        f_type = TYPE_END;
        f_len  = '0;
      end
    endcase
    f_payload = (phase == PH_HEAD)
              ? header_byte(byte_index, name_chars, exec_address, load_address)
              : rd_data;
  end

  // Next byte of a framed block
  always_comb begin
    f_byte = SYNC_BYTE;
    f_step = frame_step;
    f_sum  = running_sum;
    f_idx  = byte_index;
    f_last = 1'b0;
    unique case (frame_step)
      FS_SYNC: begin
        f_byte = START_BYTE;
        f_step = FS_TYPE;
      end
      FS_TYPE: begin
        f_byte = f_type;
        f_sum  = f_type;
        f_step = FS_LEN;
      end
      FS_LEN: begin
        f_byte = f_len;
        f_sum  = running_sum + f_len;
        f_idx  = '0;
        f_step = (f_len != '0) ? FS_DATA : FS_SUM;
      end
      FS_DATA: begin
        f_byte = f_payload;
        f_sum  = running_sum + f_payload;
        f_idx  = idx_inc;
        if (idx_inc >= f_len) begin
          f_step = FS_SUM;
        end
      end
      FS_SUM: begin
        f_byte = running_sum;
        f_step = FS_TAIL;
      end
      FS_TAIL: begin
        f_byte = SYNC_BYTE;
        f_idx  = '0;
        f_last = 1'b1;
        f_step = FS_IDLE;
      end
      default: begin
        f_byte = SYNC_BYTE;
        f_step = FS_SYNC;
      end
    endcase
  end

  // Apply one accepted transaction to the state
  always_comb begin
    phase_next        = phase;
    frame_step_next   = frame_step;
    leader_count_next = leader_count;
    byte_index_next   = byte_index;
    fill_count_next   = fill_count;
    closed_flag_next  = closed_flag;
    running_sum_next  = running_sum;
    ram_we            = 1'b0;
    valid_next        = 1'b0;
    byte_next         = '0;
    iend_next         = 1'b0;
    acc_next          = 1'b0;
    if (accept) begin
      unique case (cmd)
        CMD_PUSH: begin
          if (!closed_flag && !emitting && (phase != PH_END) && (phase != PH_DONE)
              && (fill_count < AW'(BLOCK_MAX))) begin
            ram_we          = 1'b1;
            fill_count_next = fill_count + 1'b1;
            acc_next        = 1'b1;
          end
        end
        CMD_CLOSE: begin
          closed_flag_next = 1'b1;
          acc_next         = 1'b1;
        end
        CMD_TICK: begin
          unique case (phase)
            PH_LEAD1, PH_LEAD2: begin
              valid_next = 1'b1;
              byte_next  = SYNC_BYTE;
              if (lc_inc >= BYTE_W'(LEADER_LEN)) begin
                leader_count_next = '0;
                phase_next        = (phase == PH_LEAD1) ? PH_HEAD : PH_DATA;
              end else begin
                leader_count_next = lc_inc;
              end
            end
            PH_HEAD: begin
              valid_next       = 1'b1;
              byte_next        = f_byte;
              frame_step_next  = f_step;
              running_sum_next = f_sum;
              byte_index_next  = f_idx;
              if (f_last) begin
                phase_next = PH_LEAD2;
              end
            end
            PH_DATA: begin
              if (emitting || (fill_count >= AW'(BLOCK_MAX))
                  || (closed_flag && (fill_count != '0))) begin
                valid_next       = 1'b1;
                byte_next        = f_byte;
                frame_step_next  = f_step;
                running_sum_next = f_sum;
                byte_index_next  = f_idx;
                if (f_last) begin
                  fill_count_next = '0;
                end
              end else if (closed_flag) begin
                // Idle frame step: open the end block
                phase_next       = PH_END;
                valid_next       = 1'b1;
                byte_next        = f_byte;
                frame_step_next  = f_step;
                running_sum_next = f_sum;
                byte_index_next  = f_idx;
              end
            end
            PH_END: begin
              valid_next       = 1'b1;
              byte_next        = f_byte;
              frame_step_next  = f_step;
              running_sum_next = f_sum;
              byte_index_next  = f_idx;
              if (f_last) begin
                iend_next  = 1'b1;
                phase_next = PH_DONE;
              end
            end
            default: begin
              valid_next = 1'b0;
            end
          endcase
        end
        default: begin
          acc_next = 1'b0;
        end
      endcase
    end
  end

  // Block buffer; read one index ahead so data is ready at the data step
  cbf_ram #(
    .WIDTH  (BYTE_W),
    .DEPTH  (BLOCK_MAX),
    .ADDR_W (AW)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_count),
    .wdata (data_byte),
    .raddr (byte_index_next[AW-1:0]),
    .rdata (rd_data)
  );

  // Hold configuration and framing state
  always_ff @(posedge clk) begin
    if (rst) begin
      name_chars   <= NAME_RESET;
      exec_address <= '0;
      load_address <= '0;
      phase        <= PH_LEAD1;
      frame_step   <= FS_IDLE;
      leader_count <= '0;
      byte_index   <= '0;
      fill_count   <= '0;
      closed_flag  <= 1'b0;
      running_sum  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_NAME: name_chars   <= cfg_data;
          REG_EXEC: exec_address <= cfg_data[ADDR_W-1:0];
          REG_LOAD: load_address <= cfg_data[ADDR_W-1:0];
          default:  name_chars   <= name_chars;
        endcase
      end
      phase        <= phase_next;
      frame_step   <= frame_step_next;
      leader_count <= leader_count_next;
      byte_index   <= byte_index_next;
      fill_count   <= fill_count_next;
      closed_flag  <= closed_flag_next;
      running_sum  <= running_sum_next;
    end
  end

  // Result register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_valid     <= valid_next;
      out_byte      <= byte_next;
      image_end     <= iend_next;
      push_accepted <= acc_next;
    end
  end

  `CBF_ASSERT(a_fill_bound, (fill_count <= AW'(BLOCK_MAX)), "fill count beyond buffer size")
  `CBF_ASSERT(a_no_write_emit, (ram_we |-> !emitting), "buffer written during data block")
  `CBF_ASSERT(a_end_byte, (res_valid && image_end |-> out_valid && (out_byte == SYNC_BYTE)), "image end not on trailing sync byte")
  `CBF_ASSERT(a_done_silent, (accept && (cmd == CMD_TICK) && (phase == PH_DONE) |=> res_valid && !out_valid), "byte emitted after image end")
  `CBF_ASSERT_RST(a_reset_state, (rst |=> (phase == PH_LEAD1) && (fill_count == '0) && !res_valid), "state not cleared by reset")

endmodule
